### hw/rtl/md5_pkg.sv
package md5_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       no_byte;
		logic       end_of_message;
	} md5_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_number;
		logic        last_word;
	} md5_out_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			unique case (i)
				6'd0: k = 32'hD76AA478; 6'd1: k = 32'hE8C7B756;
				6'd2: k = 32'h242070DB; 6'd3: k = 32'hC1BDCEEE;
				6'd4: k = 32'hF57C0FAF; 6'd5: k = 32'h4787C62A;
				6'd6: k = 32'hA8304613; 6'd7: k = 32'hFD469501;
				6'd8: k = 32'h698098D8; 6'd9: k = 32'h8B44F7AF;
				6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
				6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
				6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
				6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
				6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
				6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
				6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
				6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
				6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
				6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
				6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
				6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
				6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
				6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
				6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
				6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
				6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
				6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
				6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
				6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
				6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
				6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
				6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
				6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
				6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
				6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
				6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
			endcase
			return k;
		end
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] i);
		logic [4:0] s;
		begin
			unique case ({i[5:4], i[1:0]})
				4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
				4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
				4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
				4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
			endcase
			return s;
		end
	endfunction

	// Message word index used by round i.
	function automatic logic [3:0] round_g(input logic [5:0] i);
		logic [3:0] g;
		begin
			unique case (i[5:4])
				2'd0: g = i[3:0];
				2'd1: g = 4'(5 * i[3:0] + 1);
				2'd2: g = 4'(3 * i[3:0] + 5);
				default: g = 4'(7 * i[3:0]);
			endcase
			return g;
		end
	endfunction

endpackage

### hw/rtl/md5_message_digest_top.sv
// Streaming MD5 digest engine.
// Input channel (in_valid, in_stall, in_data): one beat per message byte; a
// beat with end_of_message closes the message, and with no_byte set it
// carries no byte (an empty message is one such beat).
// Output channel (out_valid, out_stall, out_data): four beats per message,
// digest words 0 to 3, last_word set on word 3.
// Bytes are written into a 16-word block memory, one per cycle while input
// is not stalled. A full block is compressed at one round per cycle: a read
// warmup step, 64 rounds and a final add, during which input is stalled. A
// byte that neither finishes a block nor ends the message leaves input open.
// Ending a message runs padding writes over one or two blocks, two length
// writes and one or two compressions, then shows the four words, one per
// cycle while out_stall is low.
// When out_stall is high the current digest beat holds; input stays stalled
// until the last word is taken. The memory read port is what sets one round
// per cycle. Reset restores the initial chaining words and a zero byte count;
// the block memory needs no clearing.
module md5_message_digest_top
	import md5_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  md5_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output md5_out_t out_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PAD  = 6'b000010,
		ST_RUN  = 6'b000100,
		ST_ADD  = 6'b001000,
		ST_LEN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] mem [16];
	logic [31:0] rd_q;
	logic [60:0] total_q;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [6:0]  rnd_q;      // rounds issued, bit 6 marks the read warmup
	logic [5:0]  pad_q;      // byte position during padding
	logic        ending_q;   // message ends after the current compression
	logic        second_q;   // padding needs a second block
	logic [1:0]  wnum_q;

	// Byte writes use a read-modify-free byte enable.
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [3:0]  wr_be;
	logic [31:0] wr_data;
	logic [3:0]  rd_addr;

	logic [5:0]  rnd;
	logic [31:0] f, t, rot;
	logic [4:0]  s;
	logic        take;
	logic [5:0]  pos;

	assign pos = total_q[5:0];
	assign rnd = rnd_q[5:0];
	assign take = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	// The warmup cycle fetches the word for round 0, each round the next one.
	assign rd_addr = (state_q == ST_RUN && !rnd_q[6]) ?
		round_g(6'(rnd_q + 7'd1)) : round_g(6'd0);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = pos[5:2];
		wr_be = 4'b0;
		wr_data = 32'h0;
		priority case (state_q)
			ST_IDLE: begin
				wr_en = take && !in_data.no_byte;
				wr_be = 4'b0001 << pos[1:0];
				wr_data = {4{in_data.data_byte}};
			end
			ST_PAD: begin
				wr_en = 1'b1;
				wr_addr = pad_q[5:2];
				wr_be = 4'b0001 << pad_q[1:0];
				wr_data = (pad_q == pos) ? 32'h80808080 : 32'h0;
			end
			ST_LEN: begin
				wr_en = 1'b1;
				wr_addr = pad_q[3] ? 4'd15 : 4'd14;
				wr_be = 4'b1111;
				wr_data = pad_q[3] ? total_q[60:29] : {total_q[28:0], 3'b000};
			end
			default: ;
		endcase
	end

	// Block memory: byte-enabled write port, registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 4; i++)
				if (wr_be[i]) mem[wr_addr][8*i +: 8] <= wr_data[8*i +: 8];
		end
		rd_q <= mem[rd_addr];
	end

	// One MD5 round on the registered message word.
	always_comb begin
		unique case (rnd[5:4])
			2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
			2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t = a_q + f + round_k(rnd) + rd_q;
		s = round_s(rnd);
		rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			h_q[0] <= INIT_A; h_q[1] <= INIT_B; h_q[2] <= INIT_C; h_q[3] <= INIT_D;
			rnd_q <= '0;
			pad_q <= '0;
			ending_q <= 1'b0;
			second_q <= 1'b0;
			wnum_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) begin
					if (!in_data.no_byte) total_q <= total_q + 61'd1;
					ending_q <= in_data.end_of_message;
					if (!in_data.no_byte && pos == 6'd63) begin
						state_q <= ST_RUN;
						rnd_q <= 7'h40;
					end else if (in_data.end_of_message) begin
						state_q <= ST_PAD;
						pad_q <= in_data.no_byte ? pos : 6'(pos + 6'd1);
					end
				end
				ST_PAD: begin
					// Marker byte then zeros through the end of the block.
					pad_q <= pad_q + 6'd1;
					if (pad_q == 6'd63) begin
						if (pos >= 6'd56 && !second_q) begin
							second_q <= 1'b1;
							state_q <= ST_RUN;
							rnd_q <= 7'h40;
						end else begin
							state_q <= ST_LEN;
							pad_q <= 6'd0;
						end
					end
				end
				ST_LEN: begin
					pad_q <= 6'd8;
					if (pad_q[3]) begin
						state_q <= ST_RUN;
						rnd_q <= 7'h40;
						second_q <= 1'b0;
						ending_q <= 1'b0;
						wnum_q <= 2'd0;
					end
				end
				ST_RUN: begin
					if (rnd_q[6]) begin
						rnd_q <= '0;
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
					end else begin
						a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
						rnd_q <= rnd_q + 7'd1;
						if (rnd == 6'd63) state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					if (second_q) begin
						// Second padding block: zero it, then write the length.
						state_q <= ST_PAD;
						pad_q <= 6'd0;
					end else if (ending_q) begin
						state_q <= ST_PAD;
						pad_q <= pos;
					end else if (pad_q[3]) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: if (!out_stall) begin
					wnum_q <= wnum_q + 2'd1;
					if (wnum_q == 2'd3) begin
						state_q <= ST_IDLE;
						total_q <= '0;
						pad_q <= '0;
						h_q[0] <= INIT_A; h_q[1] <= INIT_B;
						h_q[2] <= INIT_C; h_q[3] <= INIT_D;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word = h_q[wnum_q];
	assign out_data.word_number = wnum_q;
	assign out_data.last_word = (wnum_q == 2'd3);

endmodule
